### design/dsfp_pkg.sv
package dsfp_pkg;

	// Default build and reset values
	localparam int MAX_DECIMALS_DEF = 19;
	localparam int JOB_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 8;
	localparam logic [4:0] FRAC_DIGITS_RST = 5'd12;
	localparam logic [63:0] ATOMIC_UNITS_RST = 64'd1000000000000;

	// Register select, taken from paddr[3]
	localparam logic REG_FRAC_DIGITS = 1'b0;
	localparam logic REG_ATOMIC_UNITS = 1'b1;

	// Character codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// One parsed string, handed from the parser to the scaling pipeline
	typedef struct packed {
		logic [63:0] whole;
		logic [63:0] frac;
		logic [4:0] pad;
		logic ok;
	} job_t;

	typedef struct packed {
		logic [63:0] amount;
		logic well_formed;
	} res_t;

	function automatic logic [63:0] mul_ten_add(input logic [63:0] x, input logic [3:0] d);
		mul_ten_add = (x << 3) + (x << 1) + {60'd0, d};
	endfunction

	function automatic logic [63:0] pow_ten(input logic [4:0] n);
		case (n)
			5'd0: pow_ten = 64'd1;
			5'd1: pow_ten = 64'd10;
			5'd2: pow_ten = 64'd100;
			5'd3: pow_ten = 64'd1000;
			5'd4: pow_ten = 64'd10000;
			5'd5: pow_ten = 64'd100000;
			5'd6: pow_ten = 64'd1000000;
			5'd7: pow_ten = 64'd10000000;
			5'd8: pow_ten = 64'd100000000;
			5'd9: pow_ten = 64'd1000000000;
			5'd10: pow_ten = 64'd10000000000;
			5'd11: pow_ten = 64'd100000000000;
			5'd12: pow_ten = 64'd1000000000000;
			5'd13: pow_ten = 64'd10000000000000;
			5'd14: pow_ten = 64'd100000000000000;
			5'd15: pow_ten = 64'd1000000000000000;
			5'd16: pow_ten = 64'd10000000000000000;
			5'd17: pow_ten = 64'd100000000000000000;
			5'd18: pow_ten = 64'd1000000000000000000;
			5'd19: pow_ten = 64'd10000000000000000000;
			default: pow_ten = 64'd0;
		endcase
	endfunction

endpackage

### design/decimal_string_to_fixed_point.sv
// Decimal amount string to fixed-point atomic count.
// Input queue: drive char_code/last_char with push; a request is taken at a
// clock edge with push high and full low, one character per cycle at most.
// last_char marks the final character; only that request makes a result.
// Result queue: while empty is low, amount/well_formed hold the oldest result;
// pop high takes it. amount is whole*atomic_units + fraction*10^pad, modulo
// 2^64, and zero whenever well_formed is low.
// Config (APB, pready tied high): frac_digits at 0x0, atomic_units at 0x8,
// 64-bit data. Decoding uses paddr[3] only. Writes land in the access phase.
// Path of a result after its last character is taken: parser, job queue,
// four-stage multiply pipeline, result queue.
// Throughput: one character per cycle while full is low; the scaling pipeline
// takes one string per cycle, bounded by the result queue credits.
// Reset: parser returns to the leading whitespace phase, queues empty,
// registers load frac_digits 12 and atomic_units 10^12.
// Receiver stall: results pile up in the result queue; once its credits run
// out, jobs wait in the job queue, and full rises when that queue fills.
module decimal_string_to_fixed_point #(
	parameter int MAX_DECIMALS = dsfp_pkg::MAX_DECIMALS_DEF,
	parameter int JOB_DEPTH = dsfp_pkg::JOB_DEPTH_DEF,
	parameter int RES_DEPTH = dsfp_pkg::RES_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic [7:0] char_code,
	input  logic last_char,
	output logic empty,
	input  logic pop,
	output logic [63:0] amount,
	output logic well_formed
);

	logic [4:0] frac_digits_q;
	logic [63:0] atomic_units_q;
	logic [4:0] fd_eff;
	logic cfg_wr, accept;
	logic job_push, job_pop, job_empty, job_full;
	dsfp_pkg::job_t job_in, job_out;

	// Register port: no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == dsfp_pkg::REG_ATOMIC_UNITS) ? atomic_units_q
		: {59'd0, frac_digits_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q <= dsfp_pkg::FRAC_DIGITS_RST;
			atomic_units_q <= dsfp_pkg::ATOMIC_UNITS_RST;
		end else if (cfg_wr) begin
			case (paddr[3])
				dsfp_pkg::REG_FRAC_DIGITS: frac_digits_q <= pwdata[4:0];
				dsfp_pkg::REG_ATOMIC_UNITS: atomic_units_q <= pwdata;
				default: frac_digits_q <= frac_digits_q;
			endcase
		end
	end

	// Saturate the decimal count at the build limit
	assign fd_eff = (frac_digits_q > 5'(MAX_DECIMALS)) ? 5'(MAX_DECIMALS) : frac_digits_q;

	// Hold off characters only when the job queue cannot take a finished string
	assign full = job_full;
	assign accept = push && !job_full;

	dsfp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.char_code(char_code),
		.last_char(last_char),
		.fd(fd_eff),
		.job_push(job_push),
		.job(job_in)
	);

	dsfp_fifo #(
		.WIDTH($bits(dsfp_pkg::job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.din(job_in),
		.full(job_full),
		.pop(job_pop),
		.dout(job_out),
		.empty(job_empty)
	);

	dsfp_back #(
		.RES_DEPTH(RES_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_empty(job_empty),
		.job(job_out),
		.job_pop(job_pop),
		.atomic_units(atomic_units_q),
		.pop(pop),
		.empty(empty),
		.amount(amount),
		.well_formed(well_formed)
	);

endmodule

### design/dsfp_fifo.sv
module dsfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] din,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic push_ok, pop_ok;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok = pop && !empty;
	assign dout = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_ok) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push_ok) - CW'(pop_ok);
		end
	end

endmodule

### design/dsfp_front.sv
module dsfp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] char_code,
	input  logic last_char,
	input  logic [4:0] fd,
	output logic job_push,
	output dsfp_pkg::job_t job
);

	typedef enum logic [2:0] {PH_LEAD, PH_WHOLE, PH_FRAC, PH_TRAIL, PH_ERR} phase_t;

	phase_t phase_q, phase_n;
	logic [63:0] whole_q, whole_n, frac_q, frac_n;
	logic [4:0] count_q, count_n;
	logic seen_q, seen_n;
	logic digit, blank, ok;
	logic [7:0] dsub;
	logic [3:0] dval;

	always_comb begin
		digit = char_code inside {[dsfp_pkg::CHAR_ZERO:dsfp_pkg::CHAR_NINE]};
		blank = char_code inside {dsfp_pkg::CHAR_SPACE, [dsfp_pkg::CHAR_TAB:dsfp_pkg::CHAR_CR]};
		dsub = char_code - dsfp_pkg::CHAR_ZERO;
		dval = dsub[3:0];
		phase_n = phase_q;
		whole_n = whole_q;
		frac_n = frac_q;
		count_n = count_q;
		seen_n = seen_q;
		case (phase_q)
			PH_LEAD, PH_WHOLE: begin
				if (digit) begin
					whole_n = dsfp_pkg::mul_ten_add(whole_q, dval);
					seen_n = 1'b1;
					phase_n = PH_WHOLE;
				end else if (char_code == dsfp_pkg::CHAR_POINT) begin
					phase_n = PH_FRAC;
				end else if (blank) begin
					phase_n = (phase_q == PH_LEAD) ? PH_LEAD : PH_TRAIL;
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_FRAC: begin
				if (digit) begin
					// past the allowed decimals
					if (count_q >= fd) begin
						phase_n = PH_ERR;
					end else begin
						frac_n = dsfp_pkg::mul_ten_add(frac_q, dval);
						count_n = count_q + 5'd1;
						seen_n = 1'b1;
					end
				end else if (blank) begin
					phase_n = PH_TRAIL;
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_TRAIL: begin
				if (!blank) begin
					phase_n = PH_ERR;
				end
			end
			default: phase_n = PH_ERR;
		endcase

		ok = (phase_n != PH_ERR) && seen_n && (count_n <= fd);
		job.whole = whole_n;
		job.frac = frac_n;
		job.pad = ok ? fd - count_n : 5'd0;
		job.ok = ok;
		job_push = accept && last_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			whole_q <= '0;
			frac_q <= '0;
			count_q <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				phase_q <= PH_LEAD;
				whole_q <= '0;
				frac_q <= '0;
				count_q <= '0;
				seen_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				whole_q <= whole_n;
				frac_q <= frac_n;
				count_q <= count_n;
				seen_q <= seen_n;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_digit_empty_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (whole_q == '0 && frac_q == '0 && count_q == '0))
		else $error("accumulators moved without a digit");
	a_lead_no_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEAD) |-> !seen_q)
		else $error("leading phase after a digit");
	a_bad_no_pad: assert property (@(posedge clk) disable iff (!arst_n)
		!job.ok |-> (job.pad == '0))
		else $error("malformed string carries a pad count");
`endif

endmodule

### design/dsfp_back.sv
module dsfp_back #(
	parameter int RES_DEPTH = dsfp_pkg::RES_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_empty,
	input  dsfp_pkg::job_t job,
	output logic job_pop,
	input  logic [63:0] atomic_units,
	input  logic pop,
	output logic empty,
	output logic [63:0] amount,
	output logic well_formed
);

	localparam int CW = $clog2(RES_DEPTH + 1);

	logic [CW-1:0] credit_q;
	logic launch, pop_ok, res_full;
	logic [63:0] pw;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	logic [63:0] wll_s1, fll_s1;
	logic [31:0] wx1_s1, wx2_s1, fx1_s1, fx2_s1;
	logic [63:0] wll_s2, fll_s2;
	logic [31:0] wx_s2, fx_s2;
	logic [63:0] w_s3, f_s3;
	logic [63:0] amount_s4;
	dsfp_pkg::res_t res_in, res_out;

	// A job enters only when a result slot is reserved for it
	assign launch = !job_empty && (credit_q != '0);
	assign job_pop = launch;
	assign pop_ok = pop && !empty;
	assign pw = dsfp_pkg::pow_ten(job.pad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(RES_DEPTH);
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			credit_q <= credit_q - CW'(launch) + CW'(pop_ok);
			valid_s1 <= launch;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Low 64 bits of two 64x64 products from 32x32 partial products
	always_ff @(posedge clk) begin
		ok_s1 <= job.ok;
		wll_s1 <= job.whole[31:0] * atomic_units[31:0];
		wx1_s1 <= job.whole[63:32] * atomic_units[31:0];
		wx2_s1 <= job.whole[31:0] * atomic_units[63:32];
		fll_s1 <= job.frac[31:0] * pw[31:0];
		fx1_s1 <= job.frac[63:32] * pw[31:0];
		fx2_s1 <= job.frac[31:0] * pw[63:32];

		ok_s2 <= ok_s1;
		wll_s2 <= wll_s1;
		fll_s2 <= fll_s1;
		wx_s2 <= wx1_s1 + wx2_s1;
		fx_s2 <= fx1_s1 + fx2_s1;

		ok_s3 <= ok_s2;
		w_s3 <= wll_s2 + {wx_s2, 32'd0};
		f_s3 <= fll_s2 + {fx_s2, 32'd0};

		ok_s4 <= ok_s3;
		amount_s4 <= ok_s3 ? w_s3 + f_s3 : 64'd0;
	end

	assign res_in.amount = amount_s4;
	assign res_in.well_formed = ok_s4;

	dsfp_fifo #(
		.WIDTH($bits(dsfp_pkg::res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s4),
		.din(res_in),
		.full(res_full),
		.pop(pop),
		.dout(res_out),
		.empty(empty)
	);

	assign amount = res_out.amount;
	assign well_formed = res_out.well_formed;

`ifndef ASSERT_OFF
	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CW'(RES_DEPTH))
		else $error("credit count above result queue depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> !res_full)
		else $error("result arrived at a full result queue");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !ok_s4) |-> (amount_s4 == 64'd0))
		else $error("malformed string gave a nonzero amount");
`endif

endmodule
